// ----- rtl/cgf_pkg.sv -----
`default_nettype none

package cgf_pkg;

  // Filter shape
  localparam int ORDER      = 4;
  localparam int K_W        = (ORDER > 1) ? $clog2(ORDER) : 1;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int POLE_W     = 18;
  localparam int GAIN_W     = 24;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Stage state: signed, STATE_FRAC fraction bits
  localparam int STATE_W    = 40;
  localparam int STATE_FRAC = 8;
  localparam int POLE_FRAC  = 16;
  localparam int DELTA_W    = 42;
  localparam int SUM_W      = DELTA_W + 1;

  // Shared multiplier and accumulator
  localparam int PART_W     = 20;
  localparam int GAIN_HALF  = 12;
  localparam int MUL_W      = PART_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 82;

  // Square root unit
  localparam int ROOT_W     = 40;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 4;
  localparam int SQRT_ITER  = ROOT_W;

  // Output scaling: gain Q1.23 and state fraction
  localparam int OUT_SHIFT  = 23 + STATE_FRAC;
  localparam int Q_W        = ACC_W - OUT_SHIFT;

  localparam int CNT_W      = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLE_REAL = 2'd0,
    CFG_POLE_IMAG = 2'd1,
    CFG_GAIN      = 2'd2,
    CFG_ENV_MODE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SH_0,
    SH_12,
    SH_20,
    SH_32,
    SH_40
  } pp_shift_t;

  // Upper half of a 40-bit value as a multiplier operand
  function automatic logic signed [MUL_W-1:0] part_hi(input logic [STATE_W-1:0] x,
                                                      input logic is_signed);
    return {is_signed & x[STATE_W-1], x[STATE_W-1:PART_W]};
  endfunction

  // Lower half, always unsigned
  function automatic logic signed [MUL_W-1:0] part_lo(input logic [STATE_W-1:0] x);
    return {1'b0, x[PART_W-1:0]};
  endfunction

  function automatic logic [STATE_W-1:0] abs_state(input logic signed [STATE_W-1:0] x);
    logic [STATE_W-1:0] r;
    r = x[STATE_W-1] ? (~x + 1'b1) : x;
    return r;
  endfunction

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[SUM_W-1:STATE_W-1];
    all_zero = ~|v[SUM_W-1:STATE_W-1];
    if (all_one || all_zero) begin
      return v[STATE_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [Q_W-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[Q_W-1:OUT_W-1];
    all_zero = ~|v[Q_W-1:OUT_W-1];
    if (all_one || all_zero) begin
      return v[OUT_W-1:0];
    end else if (v[Q_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/complex_gammatone_filter_core.sv -----
`default_nettype none

// Channel  | Ports                                  | Direction | Beat
// ---------+----------------------------------------+-----------+-------------------------------
// input    | in_valid, in_stall, in_sample_in       | in        | one signed 16-bit sample
// result   | out_valid, out_stall, out_filtered     | out       | one signed 32-bit value
// config   | cfg_wr_en, cfg_index, cfg_data         | in        | register write, no read-back
//
// The time from accept to result is longer in envelope mode than in real-part mode; the
// single 21x21 multiplier (two partial products per 40-bit by 18-bit product, four per
// 40-bit by 24-bit product) and the one-bit-per-cycle square root set it.
// in_stall is high from the accept edge until the result is loaded into the output register.
// A finished result waits in the output register while the next sample is taken in.
// rst_n (synchronous) clears all stage state, loads register defaults and drops any result.

module complex_gammatone_filter_core (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire signed [cgf_pkg::SAMPLE_W-1:0]     in_sample_in,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic signed [cgf_pkg::OUT_W-1:0]       out_filtered,
  input  wire                                    cfg_wr_en,
  input  wire        [cgf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire        [cgf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cgf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DR,       // issue the four partials of a*pr - b*pi
    S_DR_FIN,   // last partial lands in the accumulator
    S_RE_UPD,   // add real delta to running value
    S_DI,       // issue the four partials of a*pi + b*pr
    S_DI_FIN,
    S_IM_UPD,   // add imaginary delta, store stage, advance
    S_SQ,       // issue re^2 + im^2 partials
    S_SQ_FIN,
    S_SQRT,     // one root bit per cycle
    S_GN,       // issue value * gain partials
    S_GN_FIN,
    S_OUT       // saturate and hand to output register
  } state_t;

  // Configuration
  logic signed [POLE_W-1:0]    pole_re_r;
  logic signed [POLE_W-1:0]    pole_im_r;
  logic        [GAIN_W-1:0]    gain_r;
  logic                        env_mode_r;

  // Sequencer
  state_t                      state_r, state_nxt;
  logic        [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic        [K_W-1:0]       k_r, k_nxt;

  // Stage state and running value
  logic signed [STATE_W-1:0]   stage_re_r [ORDER];
  logic signed [STATE_W-1:0]   stage_im_r [ORDER];
  logic signed [STATE_W-1:0]   run_re_r, run_re_nxt;
  logic signed [STATE_W-1:0]   run_im_r, run_im_nxt;
  logic                        st_we;

  // Multiplier stage
  logic                        issue;
  logic signed [MUL_W-1:0]     op_a, op_b;
  pp_shift_t                   sh_sel;
  logic                        neg_sel;
  logic signed [PROD_W-1:0]    prod_r;
  pp_shift_t                   pp_sh_r;
  logic                        pp_neg_r;
  logic                        pp_first_r;
  logic                        pp_vld_r;

  // Accumulator
  logic signed [ACC_W-1:0]     acc_r, acc_nxt;
  logic signed [ACC_W-1:0]     pp_ext, pp_term, acc_base;

  // Square root
  logic        [ROOT_W-1:0]    root_r, root_nxt;
  logic        [REM_W-1:0]     rem_r, rem_nxt;
  logic        [REM_W-1:0]     rem_sh, trial, rem_diff;

  // Output register
  logic                        out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0]     out_filtered_r, out_filtered_nxt;

  // Shared values
  logic signed [STATE_W-1:0]   pr, pi;
  logic signed [DELTA_W-1:0]   delta;
  logic signed [STATE_W-1:0]   sum_sat;
  logic signed [STATE_W-1:0]   run_sel;
  logic        [STATE_W-1:0]   abs_re, abs_im, sq_x, gn_x;
  logic signed [MUL_W-1:0]     coef_a, coef_b, gain_hi, gain_lo;
  logic signed [STATE_W-1:0]   pole_x;
  logic                        last_k;

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

  assign pr      = stage_re_r[k_r];
  assign pi      = stage_im_r[k_r];
  assign abs_re  = abs_state(run_re_r);
  assign abs_im  = abs_state(run_im_r);
  assign coef_a  = {{(MUL_W-POLE_W){pole_re_r[POLE_W-1]}}, pole_re_r};
  assign coef_b  = {{(MUL_W-POLE_W){pole_im_r[POLE_W-1]}}, pole_im_r};
  assign gain_hi = {{(MUL_W-GAIN_HALF){1'b0}}, gain_r[GAIN_W-1:GAIN_HALF]};
  assign gain_lo = {{(MUL_W-GAIN_HALF){1'b0}}, gain_r[GAIN_HALF-1:0]};
  assign last_k  = (k_r == K_W'(ORDER - 1));

  // Pole product >> 16, floor: the accumulator never exceeds 58 signed bits here
  assign delta   = acc_r[POLE_FRAC+DELTA_W-1:POLE_FRAC];
  assign run_sel = (state_r == S_IM_UPD) ? run_im_r : run_re_r;
  assign sum_sat = sat_state(SUM_W'(run_sel) + SUM_W'(delta));

  // Square root step: bring down two radicand bits, try root*4+1
  assign rem_sh   = {rem_r[REM_W-3:0], acc_r[RAD_W-1:RAD_W-2]};
  assign trial    = {2'b00, root_r, 2'b01};
  assign rem_diff = rem_sh - trial;

  // Operand selection for the shared multiplier
  always_comb begin
    issue   = 1'b0;
    op_a    = '0;
    op_b    = '0;
    sh_sel  = SH_0;
    neg_sel = 1'b0;
    pole_x  = '0;
    sq_x    = '0;
    gn_x    = '0;
    unique case (state_r)
      S_DR, S_DI: begin
        issue = 1'b1;
        if (state_r == S_DR) begin
          pole_x  = cnt_r[1] ? pi : pr;
          neg_sel = cnt_r[1];
        end else begin
          pole_x  = cnt_r[1] ? pr : pi;
        end
        op_a   = cnt_r[1] ? coef_b : coef_a;
        op_b   = cnt_r[0] ? part_lo(pole_x) : part_hi(pole_x, 1'b1);
        sh_sel = cnt_r[0] ? SH_0 : SH_20;
      end
      S_SQ: begin
        issue = 1'b1;
        sq_x  = cnt_r[2] ? abs_im : abs_re;
        op_a  = cnt_r[1] ? part_lo(sq_x) : part_hi(sq_x, 1'b0);
        op_b  = cnt_r[0] ? part_lo(sq_x) : part_hi(sq_x, 1'b0);
        case (cnt_r[1:0])
          2'd0:    sh_sel = SH_40;
          2'd3:    sh_sel = SH_0;
          default: sh_sel = SH_20;
        endcase
      end
      S_GN: begin
        issue = 1'b1;
        gn_x  = env_mode_r ? root_r : run_re_r;
        op_a  = cnt_r[1] ? part_lo(gn_x) : part_hi(gn_x, ~env_mode_r);
        op_b  = cnt_r[0] ? gain_lo : gain_hi;
        case (cnt_r[1:0])
          2'd0:    sh_sel = SH_32;
          2'd1:    sh_sel = SH_20;
          2'd2:    sh_sel = SH_12;
          default: sh_sel = SH_0;
        endcase
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  // Accumulate the registered partial product
  always_comb begin
    pp_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    unique case (pp_sh_r)
      SH_0:    pp_term = pp_ext;
      SH_12:   pp_term = pp_ext <<< 12;
      SH_20:   pp_term = pp_ext <<< 20;
      SH_32:   pp_term = pp_ext <<< 32;
      SH_40:   pp_term = pp_ext <<< 40;
      default: pp_term = pp_ext;
    endcase
    acc_base = pp_first_r ? '0 : acc_r;
    if (pp_vld_r) begin
      acc_nxt = pp_neg_r ? (acc_base - pp_term) : (acc_base + pp_term);
    end else if (state_r == S_SQRT) begin
      acc_nxt = acc_r <<< 2;
    end else begin
      acc_nxt = acc_r;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    k_nxt            = k_r;
    run_re_nxt       = run_re_r;
    run_im_nxt       = run_im_r;
    st_we            = 1'b0;
    root_nxt         = root_r;
    rem_nxt          = rem_r;
    out_valid_nxt    = out_valid_r & out_stall;
    out_filtered_nxt = out_filtered_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          run_re_nxt = STATE_W'(in_sample_in) <<< STATE_FRAC;
          run_im_nxt = '0;
          k_nxt      = '0;
          cnt_nxt    = '0;
          state_nxt  = S_DR;
        end
      end
      S_DR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt   = '0;
          state_nxt = S_DR_FIN;
        end
      end
      S_DR_FIN: begin
        state_nxt = S_RE_UPD;
      end
      S_RE_UPD: begin
        run_re_nxt = sum_sat;
        state_nxt  = S_DI;
      end
      S_DI: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt   = '0;
          state_nxt = S_DI_FIN;
        end
      end
      S_DI_FIN: begin
        state_nxt = S_IM_UPD;
      end
      S_IM_UPD: begin
        run_im_nxt = sum_sat;
        st_we      = 1'b1;
        if (last_k) begin
          state_nxt = env_mode_r ? S_SQ : S_GN;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_DR;
        end
      end
      S_SQ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[2:0] == 3'd7) begin
          cnt_nxt   = '0;
          state_nxt = S_SQ_FIN;
        end
      end
      S_SQ_FIN: begin
        root_nxt  = '0;
        rem_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (rem_sh >= trial) begin
          rem_nxt  = rem_diff;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_ITER - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_GN;
        end
      end
      S_GN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt   = '0;
          state_nxt = S_GN_FIN;
        end
      end
      S_GN_FIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the previous result is gone
        if (!out_valid_r || !out_stall) begin
          out_filtered_nxt = sat_out(acc_r[ACC_W-1:OUT_SHIFT]);
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, configuration, stage state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pp_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pole_re_r   <= '0;
      pole_im_r   <= '0;
      gain_r      <= GAIN_W'(24'h800000);
      env_mode_r  <= 1'b0;
      for (int i = 0; i < ORDER; i++) begin
        stage_re_r[i] <= '0;
        stage_im_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pp_vld_r    <= issue;
      out_valid_r <= out_valid_nxt;
      if (st_we) begin
        stage_re_r[k_r] <= run_re_r;
        stage_im_r[k_r] <= run_im_nxt;
      end
      if (cfg_wr_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_POLE_REAL: pole_re_r  <= cfg_data[POLE_W-1:0];
          CFG_POLE_IMAG: pole_im_r  <= cfg_data[POLE_W-1:0];
          CFG_GAIN:      gain_r     <= cfg_data[GAIN_W-1:0];
          CFG_ENV_MODE:  env_mode_r <= cfg_data[0];
          default:       env_mode_r <= env_mode_r;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cnt_r          <= cnt_nxt;
    k_r            <= k_nxt;
    run_re_r       <= run_re_nxt;
    run_im_r       <= run_im_nxt;
    prod_r         <= op_a * op_b;
    pp_sh_r        <= sh_sel;
    pp_neg_r       <= neg_sel;
    pp_first_r     <= (cnt_r == '0);
    acc_r          <= acc_nxt;
    root_r         <= root_nxt;
    rem_r          <= rem_nxt;
    out_filtered_r <= out_filtered_nxt;
  end

endmodule

`default_nettype wire

// ----- tb/cgf_tb_pkg.sv -----
`timescale 1ns / 1ps

package cgf_tb_pkg;
  import cgf_pkg::*;

  localparam longint STAGE_TOP = (longint'(1) <<< (STATE_W - 1)) - 1;
  localparam longint STAGE_BOT = -(longint'(1) <<< (STATE_W - 1));
  localparam longint OUT_TOP   = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint OUT_BOT   = -(longint'(1) <<< (OUT_W - 1));

  class filter_scoreboard;
    logic signed [POLE_W-1:0] pole_re;
    logic signed [POLE_W-1:0] pole_im;
    logic        [GAIN_W-1:0] gain;
    logic                     env_mode;
    longint                   stage_re[ORDER];
    longint                   stage_im[ORDER];
    logic signed [OUT_W-1:0]  expected_filtered[$];
    int                       errors;

    function new();
      pole_re  = '0;
      pole_im  = '0;
      gain     = 24'h800000;
      env_mode = 1'b0;
      errors   = 0;
      for (int k = 0; k < ORDER; k++) begin
        stage_re[k] = 0;
        stage_im[k] = 0;
      end
    endfunction

    function longint clamp40(longint v);
      if (v > STAGE_TOP) return STAGE_TOP;
      if (v < STAGE_BOT) return STAGE_BOT;
      return v;
    endfunction

    // Mirror a register write; upper data bits beyond the register width drop.
    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_POLE_REAL: pole_re  = data[POLE_W-1:0];
        CFG_POLE_IMAG: pole_im  = data[POLE_W-1:0];
        CFG_GAIN:      gain     = data[GAIN_W-1:0];
        CFG_ENV_MODE:  env_mode = data[0];
        default: ;
      endcase
    endfunction

    // Run one sample through the stage cascade and queue the scaled output.
    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      longint      a, b, re, im, pr, pq, dr, di, y, ar, ai;
      logic [83:0] sq, root, trial, ar_w, ai_w;
      logic [63:0] scaled;
      a  = longint'(pole_re);
      b  = longint'(pole_im);
      re = longint'(s);
      re = re * (longint'(1) <<< STATE_FRAC);
      im = 0;
      for (int k = 0; k < ORDER; k++) begin
        pr = stage_re[k];
        pq = stage_im[k];
        dr = (a * pr - b * pq) >>> POLE_FRAC;
        di = (a * pq + b * pr) >>> POLE_FRAC;
        re = clamp40(re + dr);
        im = clamp40(im + di);
        stage_re[k] = re;
        stage_im[k] = im;
      end
      if (env_mode) begin
        ar   = (re < 0) ? -re : re;
        ai   = (im < 0) ? -im : im;
        ar_w = 84'(ar);
        ai_w = 84'(ai);
        sq   = ar_w * ar_w + ai_w * ai_w;
        // integer square root, one bit per pass, rounded down
        root = '0;
        for (int bit_pos = ROOT_W; bit_pos >= 0; bit_pos--) begin
          trial = root | (84'd1 << bit_pos);
          if (trial * trial <= sq) root = trial;
        end
        scaled = root[63:0] * {40'd0, gain};
        scaled = scaled >> OUT_SHIFT;
        if (scaled > 64'h7FFF_FFFF) y = OUT_TOP;
        else y = scaled;
      end else begin
        y = (re * longint'({1'b0, gain})) >>> OUT_SHIFT;
        if (y > OUT_TOP) y = OUT_TOP;
        if (y < OUT_BOT) y = OUT_BOT;
      end
      expected_filtered.push_back(y[OUT_W-1:0]);
    endfunction

    function void check_result(logic signed [OUT_W-1:0] got);
      logic signed [OUT_W-1:0] want;
      if (expected_filtered.size() == 0) begin
        $display("%0t: filtered beat %0d arrived with nothing expected", $time, got);
        errors++;
      end else begin
        want = expected_filtered.pop_front();
        if (got !== want) begin
          $display("%0t: filtered mismatch, expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_filtered.size();
    endfunction
  endclass

endpackage

// ----- tb/tb_complex_gammatone_filter_core.sv -----
`timescale 1ns / 1ps

module tb_complex_gammatone_filter_core;
  import cgf_pkg::*;
  import cgf_tb_pkg::*;

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic signed [OUT_W-1:0]    out_filtered;
  logic                       cfg_wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index    = '0;
  logic [CFG_DATA_W-1:0]      cfg_data     = '0;

  // Idle percentages, set per phase by the stimulus process
  int idle_pct  = 0;
  int stall_pct = 0;

  // Idling profiles: none, sender mostly idle, receiver mostly stalled, both lightly
  int sender_idle_by_profile[4] = '{0, 82, 0, 16};
  int recv_stall_by_profile[4]  = '{0, 0, 82, 16};

  filter_scoreboard sb;

  complex_gammatone_filter_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_in (in_sample_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // Receiver: draw a fresh stall decision every cycle at the falling edge.
  always @(negedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // Sample both channels at the rising edge; a beat moves when valid is high and
  // stall is low. Input beats feed the predictor, result beats are checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_sample(in_sample_in);
      if (out_valid && !out_stall) sb.check_result(out_filtered);
    end
  end

  // Offer one sample, after a random run of idle cycles. Entered and left at a
  // falling edge; valid stays high into the next call when no gap is drawn.
  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    // hold the beat until the block takes it
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result has been seen.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // One register write: enable for a single rising edge, then low again before the task returns.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_filter(input logic [CFG_DATA_W-1:0] pr, input logic [CFG_DATA_W-1:0] pq,
                            input logic [CFG_DATA_W-1:0] g, input logic [CFG_DATA_W-1:0] env);
    write_reg(CFG_POLE_REAL, pr);
    write_reg(CFG_POLE_IMAG, pq);
    write_reg(CFG_GAIN, g);
    write_reg(CFG_ENV_MODE, env);
  endtask

  // Mix of full-range, small and rail samples so every input bit toggles.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 15) return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
    if (r < 30) return SAMPLE_W'(int'($urandom_range(127)) - 64);
    return SAMPLE_W'($urandom());
  endfunction

  initial begin
    logic signed [SAMPLE_W-1:0] extreme_samples[5];
    int                         radius, a_val, b_lim, b_val, env, profile;
    real                        a_real;
    logic [POLE_W-1:0]          pole_a, pole_b;
    logic [GAIN_W-1:0]          g;

    extreme_samples = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001};
    sb = new();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: defaults after reset (zero pole, unity gain) pass the sample through.
    foreach (extreme_samples[i]) offer_sample(extreme_samples[i]);

    // Unstable pole at the register extremes with full gain: stages and output saturate.
    wait_idle();
    set_filter(24'h01FFFF, 24'h020000, 24'hFFFFFF, 24'd0);
    repeat (4) offer_sample(16'sh7FFF);
    repeat (4) offer_sample(16'sh8000);

    // Envelope on saturated stages; magnitude stays non-negative.
    wait_idle();
    write_reg(CFG_ENV_MODE, 24'd1);
    offer_sample(16'sh8000);
    offer_sample(16'sh7FFF);
    offer_sample(16'sh0000);
    offer_sample(16'sd12345);

    // Opposite pole extremes with zero gain in envelope mode.
    wait_idle();
    set_filter(24'h020000, 24'h01FFFF, 24'd0, 24'd1);
    offer_sample(16'sd100);
    offer_sample(-16'sd100);
    offer_sample(16'sh8000);

    // Random phases: each picks a pole, gain, output mode and idling profile.
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      profile   = phase % 4;
      env       = ((phase >> 2) ^ phase) & 1;
      idle_pct  = sender_idle_by_profile[profile];
      stall_pct = recv_stall_by_profile[profile];
      if (phase == 5) begin
        // any pole at all, unstable ones included
        pole_a = POLE_W'($urandom());
        pole_b = POLE_W'($urandom());
      end else begin
        // stable pole inside a random radius below one
        radius = $urandom_range(65200, 30000);
        a_val  = int'($urandom_range(2 * radius)) - radius;
        a_real = a_val;
        b_lim  = $rtoi($sqrt(real'(radius) * real'(radius) - a_real * a_real));
        b_val  = int'($urandom_range(2 * b_lim)) - b_lim;
        pole_a = POLE_W'(a_val);
        pole_b = POLE_W'(b_val);
      end
      g = GAIN_W'($urandom());
      g = g >> $urandom_range(16);
      // random upper data bits must be ignored by the narrower registers
      set_filter({6'($urandom()), pole_a}, {6'($urandom()), pole_b}, g,
                 {23'($urandom()), env[0]});
      for (int n = 0; n < 92; n++) begin
        // pause the sender once per phase until the pipeline drains
        if (n == 46) wait_idle();
        offer_sample(pick_sample());
      end
    end

    wait_idle();
    idle_pct  = 0;
    stall_pct = 0;
    repeat (120) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- complex_gammatone_filter_core.f -----
rtl/cgf_pkg.sv
rtl/complex_gammatone_filter_core.sv
tb/cgf_tb_pkg.sv
tb/tb_complex_gammatone_filter_core.sv
